### design/lskv_pkg.sv
// Package for the linear-search key/value table: opcodes, status codes, sizes.
// No dependencies.
`default_nettype none
package lskv_pkg;
    localparam int SLOTS_DEF      = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 6;
    localparam int LIMIT_W  = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_FIND    = 3'd0;
    localparam logic [OP_W-1:0] OP_BIND    = 3'd1;
    localparam logic [OP_W-1:0] OP_TRYBIND = 3'd2;
    localparam logic [OP_W-1:0] OP_REBIND  = 3'd3;
    localparam logic [OP_W-1:0] OP_UNBIND  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;
endpackage
`default_nettype wire

### design/lskv_if.sv
// Channel interfaces: request, result and configuration words with valid/ready.
// Depends on lskv_pkg.
`default_nettype none
interface lskv_req_if;
    logic                     valid;
    logic                     ready;
    logic [lskv_pkg::OP_W-1:0]  opcode;
    logic [lskv_pkg::KEY_W-1:0] key;
    logic [lskv_pkg::VAL_W-1:0] value;
    modport source (output valid, opcode, key, value, input ready);
    modport sink   (input valid, opcode, key, value, output ready);
endinterface

interface lskv_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lskv_pkg::STATUS_W-1:0] status;
    logic [lskv_pkg::VAL_W-1:0]    value_out;
    logic [lskv_pkg::IDX_W-1:0]    slot_index;
    modport source (output valid, status, value_out, slot_index, input ready);
    modport sink   (input valid, status, value_out, slot_index, output ready);
endinterface

interface lskv_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lskv_pkg::LIMIT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### design/lskv_store.sv
// Key/value slot memory: one synchronous memory of key and value per slot,
// one write and one read port, read data registered. Depends on lskv_pkg.
`default_nettype none
module lskv_store #(
    parameter int SLOTS      = lskv_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = lskv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lskv_pkg::VALUE_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(SLOTS)-1:0]  wr_addr,
    input  wire logic [KEY_BITS-1:0]       wr_key,
    input  wire logic [VALUE_BITS-1:0]     wr_value,
    input  wire logic [$clog2(SLOTS)-1:0]  rd_addr,
    output      logic [KEY_BITS-1:0]       rd_key,
    output      logic [VALUE_BITS-1:0]     rd_value
);
    logic [KEY_BITS+VALUE_BITS-1:0] mem [SLOTS];

    // Write a slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_value};
        end
    end

    // Read a slot, read data registered
    always_ff @(posedge clk)
    begin
        {rd_key, rd_value} <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### design/lskv_ctrl.sv
// Sequencer: scans the slot memory, decides the operation, writes back,
// lowers the mark and holds the result word. Depends on lskv_pkg, lskv_if.
`default_nettype none
module lskv_ctrl #(
    parameter int SLOTS      = lskv_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = lskv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lskv_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    lskv_req_if.sink                               req,
    lskv_rsp_if.source                             rsp,
    lskv_cfg_if.sink                               cfg,
    output      logic                              wr_en,
    output      logic [$clog2(SLOTS)-1:0]          wr_addr,
    output      logic [KEY_BITS-1:0]               wr_key,
    output      logic [VALUE_BITS-1:0]             wr_value,
    output      logic [$clog2(SLOTS)-1:0]          rd_addr,
    input  wire logic [KEY_BITS-1:0]               rd_key,
    input  wire logic [VALUE_BITS-1:0]             rd_value
);
    import lskv_pkg::*;
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_DOWN, S_OUT} state_t;

    state_t                 state_reg;
    logic [SLOTS-1:0]       free_reg;
    logic [CW-1:0]          hw_reg;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [OP_W-1:0]        op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [VALUE_BITS-1:0]  val_reg;
    logic [CW-1:0]          idx_reg;     // slot being issued
    logic                   pend_reg;    // read data of slot chk_reg is valid
    logic [AW-1:0]          chk_reg;
    logic                   hit_reg;
    logic [AW-1:0]          hit_idx_reg;
    logic [VALUE_BITS-1:0]  hit_val_reg;
    logic                   lf_ok_reg;
    logic [AW-1:0]          lf_reg;
    logic [CW-1:0]          top_reg;
    logic [STATUS_W-1:0]    st_reg;
    logic [VAL_W-1:0]       vout_reg;
    logic [IDX_W-1:0]       sidx_reg;
    logic                   ovalid_reg;

    logic                   key_match;
    logic [LW-1:0]          lim_eff;
    logic [LW-1:0]          hw_ext;

    assign req.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg.ready = 1'b1;
    assign rsp.valid = ovalid_reg;
    assign rsp.status = st_reg;
    assign rsp.value_out = vout_reg;
    assign rsp.slot_index = sidx_reg;
    assign rd_addr = idx_reg[AW-1:0];

    assign key_match = pend_reg && !free_reg[chk_reg] && (rd_key == key_reg);
    assign hw_ext = LW'(hw_reg);
    assign lim_eff = (LW'(limit_reg) < LW'(SLOTS)) ? LW'(limit_reg) : LW'(SLOTS);

    // Drive memory write port from the decide step
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = lf_ok_reg ? lf_reg : hw_reg[AW-1:0];
        wr_key = key_reg;
        wr_value = val_reg;
        if (state_reg == S_DECIDE)
        begin
            if (hit_reg)
            begin
                wr_addr = hit_idx_reg;
                wr_key = key_reg;
                wr_en = (op_reg == OP_REBIND);
            end
            else if (op_reg == OP_BIND || op_reg == OP_TRYBIND || op_reg == OP_REBIND)
            begin
                wr_en = lf_ok_reg || (hw_ext < lim_eff);
            end
        end
    end

    // Hold state, free marks, mark and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            free_reg <= '1;
            hw_reg <= '0;
            limit_reg <= LIMIT_RESET;
            ovalid_reg <= 1'b0;
            pend_reg <= 1'b0;
            hit_reg <= 1'b0;
            lf_ok_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                limit_reg <= cfg.data;
            end
            if (ovalid_reg && rsp.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && !ovalid_reg)
                    begin
                        op_reg <= req.opcode;
                        key_reg <= KEY_BITS'(req.key);
                        val_reg <= VALUE_BITS'(req.value);
                        idx_reg <= '0;
                        pend_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        lf_ok_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // Check the word read last cycle, issue the next read
                    if (key_match)
                    begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= chk_reg;
                        hit_val_reg <= rd_value;
                        pend_reg <= 1'b0;
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        if (pend_reg && free_reg[chk_reg] && !lf_ok_reg)
                        begin
                            lf_ok_reg <= 1'b1;
                            lf_reg <= chk_reg;
                        end
                        if (idx_reg < hw_reg)
                        begin
                            pend_reg <= 1'b1;
                            chk_reg <= idx_reg[AW-1:0];
                            idx_reg <= idx_reg + 1'b1;
                        end
                        else
                        begin
                            pend_reg <= 1'b0;
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE:
                begin
                    if (hit_reg && op_reg <= OP_UNBIND)
                    begin
                        sidx_reg <= IDX_W'(hit_idx_reg);
                        unique case (op_reg)
                            OP_FIND:
                            begin
                                st_reg <= ST_DONE;
                                vout_reg <= VAL_W'(hit_val_reg);
                                state_reg <= S_OUT;
                            end
                            OP_BIND:
                            begin
                                st_reg <= ST_PRESENT;
                                vout_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            OP_TRYBIND, OP_REBIND:
                            begin
                                st_reg <= ST_PRESENT;
                                vout_reg <= VAL_W'(hit_val_reg);
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                st_reg <= ST_DONE;
                                vout_reg <= VAL_W'(hit_val_reg);
                                free_reg[hit_idx_reg] <= 1'b1;
                                if (CW'(hit_idx_reg) + 1'b1 == hw_reg)
                                begin
                                    top_reg <= CW'(hit_idx_reg);
                                    state_reg <= S_DOWN;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                        endcase
                    end
                    else if (!hit_reg && (op_reg == OP_BIND || op_reg == OP_TRYBIND ||
                                          op_reg == OP_REBIND))
                    begin
                        vout_reg <= '0;
                        state_reg <= S_OUT;
                        if (lf_ok_reg)
                        begin
                            st_reg <= ST_DONE;
                            sidx_reg <= IDX_W'(lf_reg);
                            free_reg[lf_reg] <= 1'b0;
                        end
                        else if (hw_ext < lim_eff)
                        begin
                            st_reg <= ST_DONE;
                            sidx_reg <= IDX_W'(hw_reg);
                            free_reg[hw_reg[AW-1:0]] <= 1'b0;
                            hw_reg <= hw_reg + 1'b1;
                        end
                        else
                        begin
                            st_reg <= ST_FULL;
                            sidx_reg <= '0;
                        end
                    end
                    else
                    begin
                        // Miss on find or unbind, or an unknown opcode
                        st_reg <= ST_NOTFOUND;
                        vout_reg <= '0;
                        sidx_reg <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_DOWN:
                begin
                    // Lower the mark one slot a cycle past free slots
                    if (top_reg != '0 && free_reg[top_reg[AW-1:0] - 1'b1])
                    begin
                        top_reg <= top_reg - 1'b1;
                    end
                    else
                    begin
                        hw_reg <= top_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### design/linear_search_key_value_table_unit.sv
// Top level of the linear-search key/value table: slot memory and sequencer.
// Depends on lskv_pkg, lskv_if, lskv_store, lskv_ctrl.
//
// Usage: a request word (opcode, key, value) enters on req; exactly one result
// word (status, value_out, slot_index) leaves on rsp. cfg writes slot_limit
// and is always ready; write it only while the block is idle.
// Flow: a request runs through the scan, decide and output steps; the scan
// covers the slots below the high-water mark hw (up to 64 at 64 slots), and
// a hit ends it early. An unbind of the top slot adds a step that lowers the
// mark past free slots. The scan reads one slot per cycle from the single
// read port of the slot memory. One request is in work at a time; the next
// is taken once the result word has been taken. If the receiver stalls, the
// result word holds and req stays not ready. Reset frees all slots, clears
// the mark, sets slot_limit to 64; key and value memory contents are not
// cleared and need no clearing pass.
`default_nettype none
module linear_search_key_value_table_unit #(
    parameter int SLOTS      = lskv_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = lskv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lskv_pkg::VALUE_BITS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    lskv_req_if.sink   req,
    lskv_rsp_if.source rsp,
    lskv_cfg_if.sink   cfg
);
    import lskv_pkg::*;
    localparam int AW = $clog2(SLOTS);

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_value;
    logic [AW-1:0]         rd_addr;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;

    // Slot memory
    lskv_store #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key),
        .wr_value(wr_value), .rd_addr(rd_addr), .rd_key(rd_key), .rd_value(rd_value)
    );

    // Sequencer
    lskv_ctrl #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key), .wr_value(wr_value),
        .rd_addr(rd_addr), .rd_key(rd_key), .rd_value(rd_value)
    );
endmodule
`default_nettype wire

### sim/linear_search_key_value_table_unit_tb.sv
// Testbench for the linear-search key/value table: directed and random request words,
// each result word checked against an in-bench table predictor.
// Depends on lskv_pkg, lskv_if and the linear_search_key_value_table_unit RTL.
`default_nettype none
module linear_search_key_value_table_unit_tb;
    import lskv_pkg::*;

    localparam int NSLOT = 64;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    value_out;
        logic [IDX_W-1:0]    slot_index;
    } answer_t;

    logic clk;
    logic rst_n;
    lskv_req_if req ();
    lskv_rsp_if rsp ();
    lskv_cfg_if cfg ();

    linear_search_key_value_table_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Predictor copy of the table
    logic [KEY_W-1:0] tbl_key [NSLOT];
    logic [VAL_W-1:0] tbl_val [NSLOT];
    logic             tbl_free [NSLOT];
    int               tbl_mark;
    int               tbl_limit;

    answer_t answers_due [$];
    int      mismatches;
    int      cycles;
    bit      idle_on;
    int      hold_off;
    bit      long_hold;
    logic [KEY_W-1:0] key_pool [8];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // Compute the answer for one request word and update the table
    function automatic answer_t table_predict(input logic [OP_W-1:0] op,
                                              input logic [KEY_W-1:0] k,
                                              input logic [VAL_W-1:0] v);
        answer_t a;
        int hit;
        int low_free;
        int lim;
        int s;
        int top;
        hit = -1;
        low_free = -1;
        a = '0;
        a.status = ST_NOTFOUND;
        for (int i = 0; i < tbl_mark; i++)
        begin
            if (!tbl_free[i])
            begin
                if (tbl_key[i] == k && hit < 0)
                    hit = i;
            end
            else if (low_free < 0 && hit < 0)
                low_free = i;
        end
        if (op > OP_UNBIND || (hit < 0 && (op == OP_FIND || op == OP_UNBIND)))
            return a;
        if (hit < 0)
        begin
            lim = (tbl_limit < NSLOT) ? tbl_limit : NSLOT;
            if (low_free >= 0)
                s = low_free;
            else if (tbl_mark < lim)
            begin
                s = tbl_mark;
                tbl_mark++;
            end
            else
            begin
                a.status = ST_FULL;
                return a;
            end
            tbl_key[s] = k;
            tbl_val[s] = v;
            tbl_free[s] = 1'b0;
            a.status = ST_DONE;
            a.slot_index = s[IDX_W-1:0];
            return a;
        end
        a.slot_index = hit[IDX_W-1:0];
        case (op)
            OP_FIND:
            begin
                a.status = ST_DONE;
                a.value_out = tbl_val[hit];
            end
            OP_BIND:
                a.status = ST_PRESENT;
            OP_TRYBIND:
            begin
                a.status = ST_PRESENT;
                a.value_out = tbl_val[hit];
            end
            OP_REBIND:
            begin
                a.status = ST_PRESENT;
                a.value_out = tbl_val[hit];
                tbl_val[hit] = v;
            end
            default:
            begin
                tbl_free[hit] = 1'b1;
                a.status = ST_DONE;
                a.value_out = tbl_val[hit];
                if (hit + 1 == tbl_mark)
                begin
                    top = hit;
                    while (top > 0 && tbl_free[top-1])
                        top--;
                    tbl_mark = top;
                end
            end
        endcase
        return a;
    endfunction

    // Send one request word, with an optional random gap first; valid stays
    // high afterwards until the next word or an explicit drop
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        req.valid  <= 1'b1;
        req.opcode <= op;
        req.key    <= k;
        req.value  <= v;
        do @(posedge clk); while (!req.ready);
        answers_due.push_back(table_predict(op, k, v));
        @(negedge clk);
    endtask

    // Write slot_limit while idle
    task automatic write_limit(input int lim);
        req.valid <= 1'b0;
        wait (answers_due.size() == 0);
        repeat (80) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= lim[LIMIT_W-1:0];
        do @(posedge clk); while (!cfg.ready);
        tbl_limit = lim;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Receiver: random stalls, long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (long_hold)
            rsp.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            rsp.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            rsp.ready <= 1'b0;
            hold_off <= $urandom_range(0, 12);
        end
        else
            rsp.ready <= 1'b1;
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answers_due.size() == 0)
                report("unexpected word", 64'({rsp.status, rsp.slot_index}), 64'(0));
            else
            begin
                want = answers_due.pop_front();
                if (rsp.status !== want.status)
                    report("status", 64'(rsp.status), 64'(want.status));
                if (rsp.value_out !== want.value_out)
                    report("value_out", 64'(rsp.value_out), 64'(want.value_out));
                if (rsp.slot_index !== want.slot_index)
                    report("slot_index", 64'(rsp.slot_index), 64'(want.slot_index));
            end
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        return ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
    endfunction

    task automatic test_directed();
        send_request(OP_FIND, 32'h0, 32'h0);
        send_request(OP_UNBIND, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_BIND, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_BIND, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_BIND, 32'h0, 32'h1234);
        send_request(OP_TRYBIND, 32'hFFFF_FFFF, 32'h55);
        send_request(OP_TRYBIND, 32'hA5A5_5A5A, 32'hAAAA_5555);
        send_request(OP_FIND, 32'h0, 32'h0);
        send_request(OP_REBIND, 32'h0, 32'h5555_AAAA);
        send_request(OP_REBIND, 32'h7777, 32'h1);
        send_request(OP_FIND, 32'h0, 32'h0);
        send_request(OP_UNBIND, 32'h0, 32'h0);
        send_request(OP_BIND, 32'h8888, 32'h2);
        send_request(OP_UNBIND, 32'h7777, 32'h0);
        send_request(OP_UNBIND, 32'hA5A5_5A5A, 32'h0);
        send_request(3'd5, 32'h8888, 32'h0);
        send_request(3'd6, 32'h0, 32'h0);
        send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fill to the limit, then hit full, then drain from the top
    task automatic test_full(input int count);
        for (int i = 0; i < count; i++)
            send_request(OP_BIND, 32'h100 + i, $urandom());
        send_request(OP_BIND, 32'hDEAD_BEEF, 32'h1);
        send_request(OP_TRYBIND, 32'hDEAD_BEEF, 32'h1);
        for (int i = count - 1; i >= 0; i--)
            send_request(OP_UNBIND, 32'h100 + i, 32'h0);
    endtask

    // Hold off the receiver so the block holds its result word and stalls its input
    task automatic test_backpressure();
        fork
            begin
                @(posedge clk);
                long_hold = 1'b1;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 10; i++)
            send_request(OP_BIND, 32'h900 + i, $urandom());
    endtask

    task automatic test_random(input int count);
        logic [OP_W-1:0] op;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(5, 7))
                                              : OP_W'($urandom_range(0, 4));
            send_request(op, pick_key(), $urandom());
        end
    endtask

    initial
    begin
        int settle;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.opcode = '0;
        req.key = '0;
        req.value = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        mismatches = 0;
        idle_on = 1'b1;
        tbl_mark = 0;
        tbl_limit = 64;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_free[i] = 1'b1;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full(64);
        test_backpressure();
        write_limit(4);
        test_full(4);
        test_random(200);
        write_limit(0);
        send_request(OP_BIND, 32'h4242, 32'h1);
        test_random(300);
        write_limit(1);
        test_full(1);
        write_limit(127);
        test_random(400);
        write_limit(64);
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom();
        test_random(300);
        idle_on = 1'b0;
        test_random(250);
        req.valid <= 1'b0;

        settle = 0;
        while (answers_due.size() != 0 && settle < 100000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (100) @(posedge clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
